### rtl/mrd_pkg.sv
// Shared types, constants and the divider step for the mixed-radix digit core.
// No dependencies.
package mrd_pkg;

	localparam int DIGITS         = 4;
	localparam int RADIX_REGS     = 3;
	localparam int VALUE_W        = 32;
	localparam int RADIX_W        = 16;
	localparam int COUNT_W        = 3;
	localparam int STEP_BITS      = 8;
	localparam int STAGES_PER_DIV = VALUE_W / STEP_BITS;
	localparam int DIV_STAGES     = RADIX_REGS * STAGES_PER_DIV;
	localparam int ADDR_W         = 4;

	// register indexes
	localparam logic [1:0] REG_RADIX_0     = 2'd0;
	localparam logic [1:0] REG_RADIX_1     = 2'd1;
	localparam logic [1:0] REG_RADIX_2     = 2'd2;
	localparam logic [1:0] REG_DIGIT_COUNT = 2'd3;

	// long division working pair: partial remainder and shifting numerator/quotient
	typedef struct packed {
		logic [RADIX_W-1:0] rem;
		logic [VALUE_W-1:0] num;
	} work_t;

	// quotients and remainders already settled, carried alongside the division
	typedef struct packed {
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] q1;
		logic [VALUE_W-1:0] q2;
		logic [RADIX_W-1:0] r0;
		logic [RADIX_W-1:0] r1;
	} side_t;

	// STEP_BITS restoring division steps
	function automatic work_t div_steps(input work_t w, input logic [RADIX_W-1:0] d);
		work_t            r;
		logic [RADIX_W:0] t;
		r = w;
		for (int i = 0; i < STEP_BITS; i++) begin
			t     = {r.rem, r.num[VALUE_W-1]};
			r.num = {r.num[VALUE_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t        = t - {1'b0, d};
				r.num[0] = 1'b1;
			end
			r.rem = t[RADIX_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/mrd_div_stage.sv
// One registered slice of the divider pipeline: STEP_BITS quotient bits.
// Depends on mrd_pkg.
module mrd_div_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        vin,
	input  mrd_pkg::side_t              side_in,
	input  mrd_pkg::work_t              work_in,
	input  logic [mrd_pkg::RADIX_W-1:0] divisor,
	output logic                        vout,
	output mrd_pkg::side_t              side_out,
	output mrd_pkg::work_t              work_out
);

	logic           valid_s1;
	mrd_pkg::side_t side_s1;
	mrd_pkg::work_t work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			work_s1 <= mrd_pkg::div_steps(work_in, divisor);
		end
	end

	assign vout     = valid_s1;
	assign side_out = side_s1;
	assign work_out = work_s1;

endmodule

### rtl/mixed_radix_to_digits_core.sv
// Top level of the mixed-radix digit core: APB registers, divider pipeline, output stage.
// Depends on mrd_pkg and mrd_div_stage.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid / in_stall       | flat_value
//  out     | out_valid / out_stall     | digit_zero, digit_one, digit_two, digit_three
//  cfg     | APB psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One word accepted per cycle while in_stall is low; 12 divider slices of 8 bits (three
// successive 32/16 divisions by radix_0..2), then the digit select register.
// Reset clears the valid bits and loads radices 2,2,2 and digit_count 4.
// out_stall on a valid output word freezes the whole pipeline; in_stall is high only while a held output
// word is stalled, so nothing is dropped or repeated.
module mixed_radix_to_digits_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mrd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mrd_pkg::VALUE_W-1:0]  flat_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mrd_pkg::VALUE_W-1:0]  digit_zero,
	output logic [mrd_pkg::VALUE_W-1:0]  digit_one,
	output logic [mrd_pkg::VALUE_W-1:0]  digit_two,
	output logic [mrd_pkg::VALUE_W-1:0]  digit_three
);

	localparam int NS = mrd_pkg::DIV_STAGES;
	localparam int VW = mrd_pkg::VALUE_W;
	localparam int RW = mrd_pkg::RADIX_W;

	// ---- configuration registers
	logic [RW-1:0]                 radix_q [mrd_pkg::RADIX_REGS];
	logic [mrd_pkg::COUNT_W-1:0]   count_q;
	logic                          wr_en;
	logic [1:0]                    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q[0] <= RW'(2);
			radix_q[1] <= RW'(2);
			radix_q[2] <= RW'(2);
			count_q    <= mrd_pkg::COUNT_W'(4);
		end else if (wr_en) begin
			unique case (reg_idx)
				mrd_pkg::REG_RADIX_0:     radix_q[0] <= pwdata[RW-1:0];
				mrd_pkg::REG_RADIX_1:     radix_q[1] <= pwdata[RW-1:0];
				mrd_pkg::REG_RADIX_2:     radix_q[2] <= pwdata[RW-1:0];
				mrd_pkg::REG_DIGIT_COUNT: count_q    <= pwdata[mrd_pkg::COUNT_W-1:0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mrd_pkg::REG_RADIX_0:     prdata = {16'd0, radix_q[0]};
			mrd_pkg::REG_RADIX_1:     prdata = {16'd0, radix_q[1]};
			mrd_pkg::REG_RADIX_2:     prdata = {16'd0, radix_q[2]};
			mrd_pkg::REG_DIGIT_COUNT: prdata = {29'd0, count_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---- pipeline, one global advance
	logic adv;
	assign adv      = ~(out_valid & out_stall);
	assign in_stall = ~adv;

	logic           st_v    [NS+1];
	mrd_pkg::side_t st_side [NS+1];
	mrd_pkg::work_t st_work [NS+1];

	assign st_v[0]         = in_valid;
	assign st_side[0].v    = flat_value;
	assign st_side[0].q1   = '0;
	assign st_side[0].q2   = '0;
	assign st_side[0].r0   = '0;
	assign st_side[0].r1   = '0;
	assign st_work[0].rem  = '0;
	assign st_work[0].num  = flat_value;

	for (genvar s = 0; s < NS; s++) begin : g_div
		localparam int DIV = s / mrd_pkg::STAGES_PER_DIV;
		mrd_pkg::side_t side_in;
		mrd_pkg::work_t work_in;

		always_comb begin
			side_in     = st_side[s];
			work_in     = st_work[s];
			// each new division starts from the previous quotient (the input value for the first) with zero remainder
			if ((s % mrd_pkg::STAGES_PER_DIV) == 0)
				work_in.rem = '0;
			if (s == mrd_pkg::STAGES_PER_DIV) begin
				side_in.q1 = st_work[s].num;
				side_in.r0 = st_work[s].rem;
			end
			if (s == 2 * mrd_pkg::STAGES_PER_DIV) begin
				side_in.q2 = st_work[s].num;
				side_in.r1 = st_work[s].rem;
			end
		end

		mrd_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.vin      (st_v[s]),
			.side_in  (side_in),
			.work_in  (work_in),
			.divisor  (radix_q[DIV]),
			.vout     (st_v[s+1]),
			.side_out (st_side[s+1]),
			.work_out (st_work[s+1])
		);
	end

	// ---- digit select: digit k below the top is floor(v/wk) mod rk, top is unreduced.
	// A zero radix makes every higher weight zero: those digits read all ones and the
	// digit at the zero radix becomes the unreduced top.
	logic [2:0]    n_eff;
	logic [1:0]    top_zero;
	logic [2:0]    top;
	logic [VW-1:0] quo   [mrd_pkg::DIGITS];
	logic [VW-1:0] rem   [mrd_pkg::DIGITS];
	logic [VW-1:0] dig_d [mrd_pkg::DIGITS];

	always_comb begin
		n_eff = (count_q > 3'd4) ? 3'd4 : count_q;
		priority if (radix_q[0] == '0) top_zero = 2'd0;
		else if (radix_q[1] == '0)     top_zero = 2'd1;
		else if (radix_q[2] == '0)     top_zero = 2'd2;
		else                           top_zero = 2'd3;
		top = ((n_eff - 3'd1) < {1'b0, top_zero}) ? (n_eff - 3'd1) : {1'b0, top_zero};

		quo[0] = st_side[NS].v;
		quo[1] = st_side[NS].q1;
		quo[2] = st_side[NS].q2;
		quo[3] = st_work[NS].num;
		rem[0] = {16'd0, st_side[NS].r0};
		rem[1] = {16'd0, st_side[NS].r1};
		rem[2] = {16'd0, st_work[NS].rem};
		rem[3] = '0;

		for (int k = 0; k < mrd_pkg::DIGITS; k++) begin
			if (3'(k) >= n_eff)   dig_d[k] = '0;
			else if (3'(k) < top) dig_d[k] = rem[k];
			else if (3'(k) == top) dig_d[k] = quo[k];
			else                  dig_d[k] = '1;
		end
	end

	// ---- output register
	logic          out_valid_q;
	logic [VW-1:0] dig_q [mrd_pkg::DIGITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= st_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < mrd_pkg::DIGITS; k++)
				dig_q[k] <= dig_d[k];
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_zero  = dig_q[0];
	assign digit_one   = dig_q[1];
	assign digit_two   = dig_q[2];
	assign digit_three = dig_q[3];

endmodule

### rtl/mrd_checker.sv
// Port-level assertions for the mixed-radix digit core, bound to the top level.
// Depends on mixed_radix_to_digits_core.
module mrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        pready,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digit_zero,
	input logic [31:0] digit_three
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_zero) && $stable(digit_three))
		else $error("stalled output word changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register access waited");

endmodule

bind mixed_radix_to_digits_core mrd_checker u_mrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.psel        (psel),
	.pready      (pready),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digit_zero  (digit_zero),
	.digit_three (digit_three)
);

### verif/mixed_radix_to_digits_core_test.sv
`timescale 1ns / 1ps
// Testbench for mixed_radix_to_digits_core: directed and random flat values under several
// radix settings, checked word by word against a digit predictor. Depends on mrd_pkg.
module mixed_radix_to_digits_core_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;   // covers the pipeline depth, plus margin
	localparam int LONG_HOLD      = 300;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

	typedef struct {
		logic [mrd_pkg::VALUE_W-1:0] d0;
		logic [mrd_pkg::VALUE_W-1:0] d1;
		logic [mrd_pkg::VALUE_W-1:0] d2;
		logic [mrd_pkg::VALUE_W-1:0] d3;
	} digits_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [mrd_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [mrd_pkg::VALUE_W-1:0]  flat_value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [mrd_pkg::VALUE_W-1:0]  digit_zero, digit_one, digit_two, digit_three;

	// predictor copy of the registers
	logic [mrd_pkg::RADIX_W-1:0]  radix_cfg [mrd_pkg::RADIX_REGS];
	logic [mrd_pkg::COUNT_W-1:0]  count_cfg;

	digits_t                      expected_digits [$];
	idle_t                        idle_mode = IDLE_NONE;
	int                           mismatches = 0;
	int                           idle_cycles = 0;
	int                           hold_left = 0;
	bit                           hold_req = 1'b0;

	always #5 clk = ~clk;

	mixed_radix_to_digits_core dut (.*);

	// Digits from the top position in use downwards; a zero weight (from a zero
	// radix) reads all ones and leaves the remainder untouched.
	function automatic digits_t split_flat(input logic [mrd_pkg::VALUE_W-1:0] v);
		logic [63:0]                 w [4];
		logic [63:0]                 rem;
		logic [mrd_pkg::VALUE_W-1:0] d [4];
		int                          n;
		digits_t                     r;
		rem  = {32'd0, v};
		n    = (count_cfg > 3'd4) ? 4 : int'(count_cfg);
		w[0] = 64'd1;
		for (int k = 1; k < 4; k++)
			w[k] = w[k-1] * {48'd0, radix_cfg[k-1]};
		for (int k = 0; k < 4; k++)
			d[k] = '0;
		for (int k = n - 1; k >= 0; k--) begin
			if (w[k] == 64'd0) begin
				d[k] = 32'hFFFF_FFFF;
			end else begin
				d[k] = 32'(rem / w[k]);
				rem  = rem % w[k];
			end
		end
		r.d0 = d[0];
		r.d1 = d[1];
		r.d2 = d[2];
		r.d3 = d[3];
		return r;
	endfunction

	function automatic bit send_gap();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 82;
			IDLE_BOTH: return $urandom_range(99) < 12;
			default:   return 1'b0;
		endcase
	endfunction

	// offer one word; valid stays high into the next call when there is no gap
	task automatic send_word(input logic [mrd_pkg::VALUE_W-1:0] v);
		while (send_gap()) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		flat_value <= v;
		do @(posedge clk); while (in_stall);
		expected_digits = {expected_digits, split_flat(v)};
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_digits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup then access; only called while the pipeline is empty
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		quiesce();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= mrd_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == mrd_pkg::REG_DIGIT_COUNT)
			count_cfg = val[mrd_pkg::COUNT_W-1:0];
		else
			radix_cfg[idx] = val[mrd_pkg::RADIX_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_radices(input logic [15:0] r0, r1, r2, input logic [2:0] n);
		write_reg(mrd_pkg::REG_RADIX_0, {16'd0, r0});
		write_reg(mrd_pkg::REG_RADIX_1, {16'd0, r1});
		write_reg(mrd_pkg::REG_RADIX_2, {16'd0, r2});
		write_reg(mrd_pkg::REG_DIGIT_COUNT, {29'd0, n});
	endtask

	function automatic logic [15:0] pick_radix();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(2, 16));
			4: return 16'($urandom_range(2, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [mrd_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(4))
			0: return 32'($urandom_range(0, 255));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	// reset settings: radices 2,2,2 with four digits
	task automatic test_reset_settings();
		send_word(32'd0);
		send_word(32'd1);
		send_word(32'd7);
		send_word(32'd8);
		send_word(32'hFFFF_FFFF);
	endtask

	// every digit count, including zero and the saturating counts above four
	task automatic test_digit_counts();
		for (int n = 0; n < 8; n++) begin
			set_radices(16'd10, 16'd100, 16'd7, 3'(n));
			send_word(32'd123_456_789);
		end
	endtask

	// zero radix in each position, and the extreme radices
	task automatic test_extreme_radices();
		set_radices(16'd0, 16'd3, 16'd5, 3'd4);
		send_word(32'hDEAD_BEEF);
		set_radices(16'd3, 16'd0, 16'd5, 3'd4);
		send_word(32'hDEAD_BEEF);
		set_radices(16'd3, 16'd5, 16'd0, 3'd4);
		send_word(32'hDEAD_BEEF);
		set_radices(16'd1, 16'd1, 16'd1, 3'd4);
		send_word(32'hFFFF_FFFF);
		set_radices(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0001_0000);
		// top radix is unused with three digits
		set_radices(16'hFFFF, 16'h0101, 16'd0, 3'd3);
		send_word(32'hFFFF_FFFF);
	endtask

	// random settings and values under each idling pattern
	task automatic test_random_traffic();
		idle_t modes [4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
		for (int p = 0; p < 16; p++) begin
			quiesce();
			idle_mode = modes[p % 4];
			set_radices(pick_radix(), pick_radix(), pick_radix(), 3'($urandom_range(0, 7)));
			for (int i = 0; i < 50; i++)
				send_word(pick_value());
		end
		idle_mode = IDLE_NONE;
	endtask

	// receiver holds off for a long stretch while words keep coming
	task automatic test_backpressure();
		quiesce();
		set_radices(16'd6, 16'd24, 16'd60, 3'd4);
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word($urandom);
	endtask

	// receiver stall; a hold request overrides the random pattern
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				IDLE_RECV: out_stall <= $urandom_range(99) < 82;
				IDLE_BOTH: out_stall <= $urandom_range(99) < 12;
				default:   out_stall <= 1'b0;
			endcase
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_digits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %h %h %h %h",
						digit_zero, digit_one, digit_two, digit_three);
			end else begin
				digits_t e;
				e = expected_digits.pop_front();
				if (e.d0 !== digit_zero || e.d1 !== digit_one ||
				    e.d2 !== digit_two || e.d3 !== digit_three) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digit mismatch: exp %h %h %h %h got %h %h %h %h",
							e.d0, e.d1, e.d2, e.d3,
							digit_zero, digit_one, digit_two, digit_three);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < mrd_pkg::RADIX_REGS; i++)
			radix_cfg[i] = 16'd2;
		count_cfg = 3'd4;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_reset_settings();
		test_digit_counts();
		test_extreme_radices();
		test_random_traffic();
		test_backpressure();
		quiesce();
		if (mismatches == 0 && expected_digits.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
